### rtl/core/mm64_pkg.sv
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared types, constants and helpers for the streaming MurmurHash64A block.
// ----------------------------------------------------------------------------
`default_nettype none

package mm64_pkg;

  // hash constants
  localparam int unsigned    WORD_BITS   = 64;
  localparam int unsigned    HALF_BITS   = WORD_BITS / 2;
  localparam int unsigned    LENGTH_BITS = 16;
  localparam int unsigned    SHIFT_R     = 47;
  localparam logic [63:0]    MUL_M       = 64'hc6a4a7935bd1e995;
  localparam logic [63:0]    SEED_RESET  = 64'h0234233242324323;

  // partial products per 64x64 low-half multiply
  localparam int unsigned    MUL_STEPS   = 3;
  localparam int unsigned    STEP_BITS   = $clog2(MUL_STEPS);

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [STEP_BITS-1:0]   step_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_KMUL1,
    S_KMUL2,
    S_HMUL,
    S_FMUL,
    S_OUT
  } state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    SEL_LEN,
    SEL_K,
    SEL_HK,
    SEL_HFIN
  } mul_sel_t;

  // product write-back
  typedef enum logic [2:0] {
    WB_NONE,
    WB_SEED,
    WB_KXS,
    WB_K,
    WB_H,
    WB_HXS
  } wb_t;

  // controller to datapath
  typedef struct packed {
    logic     take;
    logic     mul_run;
    mul_sel_t mul_sel;
    wb_t      wb;
    logic     load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic init;
    logic last;
    logic tail_zero;
    logic len_zero;
    logic mul_done;
    logic out_free;
  } stat_t;

  // keep the low n bytes of a word
  function automatic word_t tail_mask(input logic [2:0] n);
    word_t m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // xor-shift step of the mixer and finalizer
  function automatic word_t xor_shift(input word_t v);
    return v ^ (v >> SHIFT_R);
  endfunction

endpackage

`default_nettype wire

### rtl/core/mm64_ifs.sv
// ----------------------------------------------------------------------------
// mm64 stream interfaces
// Valid/ready channels for message words in and finished hashes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm64_in_if;
  logic                            valid;
  logic                            ready;
  logic [63:0]                     data_word;
  logic [mm64_pkg::LENGTH_BITS-1:0] total_length;
  logic                            is_last;

  modport source (output valid, output data_word, output total_length,
                  output is_last, input ready);
  modport sink   (input valid, input data_word, input total_length,
                  input is_last, output ready);
endinterface

interface mm64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

### rtl/core/murmur64a_hash_stream.sv
// ----------------------------------------------------------------------------
// murmur64a_hash_stream
// Streaming MurmurHash64A over little-endian 64-bit message words.
//
// in_ch carries one beat per word: data_word, total_length (taken from the
// first beat of a message only) and is_last. An empty message is a single
// beat with length zero and is_last set. out_ch gives one hash_value beat
// per message. The seed is written through cfg_we/cfg_wdata; the user must
// do so only while idle, as the block does not enforce it. It applies from
// the next message start. Every 64-bit multiply runs as three 32x32 partial
// products on one shared multiplier and sets the pace: a middle word takes
// two key multiplies and a hash multiply, the first word of a message also
// a seeding multiply with the length. The last beat adds the finalizer
// multiply after the key and hash multiplies for a full word, after the hash
// multiply alone for a tail, or on its own for a zero-length last beat.
// While a finished hash waits, the next message's words are still taken;
// a second hash holds in the running hash register until the receiver takes
// the first. Reset (rst, synchronous) restores the default seed and starts
// a new message; no stored hash survives it.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur64a_hash_stream (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  mm64_in_if.sink          in_ch,
  mm64_out_if.source       out_ch
);

  mm64_pkg::cmd_t  cmd;
  mm64_pkg::stat_t st;

  // sequencer
  mm64_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // hash datapath
  mm64_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### rtl/core/mm64_mul.sv
// ----------------------------------------------------------------------------
// mm64_mul
// Low 64 bits of a * MUL_M from three 32x32 partial products, one per cycle
// while run is held high, on a single shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mm64_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            run,
  input  wire mm64_pkg::word_t a,
  output logic                 done,
  output mm64_pkg::word_t      p
);

  localparam int unsigned H = mm64_pkg::HALF_BITS;
  localparam mm64_pkg::step_t LAST_STEP = mm64_pkg::step_t'(mm64_pkg::MUL_STEPS - 1);

  mm64_pkg::step_t  cnt;
  logic [H-1:0]     xs;
  logic [H-1:0]     ys;
  logic [2*H-1:0]   pp;
  mm64_pkg::word_t  acc;

  // operand halves: lo*lo, lo*hi, hi*lo
  always_comb begin
    xs = (cnt == LAST_STEP) ? a[2*H-1:H] : a[H-1:0];
    ys = (cnt == mm64_pkg::step_t'(1)) ? mm64_pkg::MUL_M[2*H-1:H]
                                       : mm64_pkg::MUL_M[H-1:0];
    pp = xs * ys;
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == LAST_STEP);
      if (run) begin
        cnt <= (cnt == LAST_STEP) ? '0 : cnt + mm64_pkg::step_t'(1);
      end
    end
  end

  // accumulate partial products
  always_ff @(posedge clk) begin
    if (run) begin
      if (cnt == '0) begin
        acc <= pp;
      end else begin
        acc[2*H-1:H] <= acc[2*H-1:H] + pp[H-1:0];
      end
    end
  end

  assign p = acc;

endmodule

`default_nettype wire

### rtl/core/mm64_ctrl.sv
// ----------------------------------------------------------------------------
// mm64_ctrl
// Sequencer that walks one word through seeding, mixing and finalizing.
// ----------------------------------------------------------------------------
`default_nettype none

module mm64_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mm64_pkg::stat_t st,
  output mm64_pkg::cmd_t       cmd
);

  mm64_pkg::state_t state;
  mm64_pkg::state_t state_next;
  mm64_pkg::state_t route;

  // path after seeding
  always_comb begin
    priority if (!st.last)     route = mm64_pkg::S_KMUL1;
    else if (!st.tail_zero)    route = mm64_pkg::S_HMUL;
    else if (!st.len_zero)     route = mm64_pkg::S_KMUL1;
    else                       route = mm64_pkg::S_FMUL;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm64_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mm64_pkg::S_IDLE:  if (st.in_valid) state_next = mm64_pkg::S_INIT;
      mm64_pkg::S_INIT:  if (!st.init || st.mul_done) state_next = route;
      mm64_pkg::S_KMUL1: if (st.mul_done) state_next = mm64_pkg::S_KMUL2;
      mm64_pkg::S_KMUL2: if (st.mul_done) state_next = mm64_pkg::S_HMUL;
      mm64_pkg::S_HMUL: begin
        if (st.mul_done) state_next = st.last ? mm64_pkg::S_FMUL : mm64_pkg::S_IDLE;
      end
      mm64_pkg::S_FMUL:  if (st.mul_done) state_next = mm64_pkg::S_OUT;
      mm64_pkg::S_OUT:   if (st.out_free) state_next = mm64_pkg::S_IDLE;
      default:           state_next = mm64_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = mm64_pkg::SEL_K;
    cmd.wb       = mm64_pkg::WB_NONE;
    unique case (state)
      mm64_pkg::S_IDLE: cmd.take = 1'b1;
      mm64_pkg::S_INIT: begin
        cmd.mul_sel = mm64_pkg::SEL_LEN;
        cmd.mul_run = st.init && !st.mul_done;
        if (st.mul_done) cmd.wb = mm64_pkg::WB_SEED;
      end
      mm64_pkg::S_KMUL1: begin
        cmd.mul_run = !st.mul_done;
        if (st.mul_done) cmd.wb = mm64_pkg::WB_KXS;
      end
      mm64_pkg::S_KMUL2: begin
        cmd.mul_run = !st.mul_done;
        if (st.mul_done) cmd.wb = mm64_pkg::WB_K;
      end
      mm64_pkg::S_HMUL: begin
        cmd.mul_sel = mm64_pkg::SEL_HK;
        cmd.mul_run = !st.mul_done;
        if (st.mul_done) cmd.wb = mm64_pkg::WB_H;
      end
      mm64_pkg::S_FMUL: begin
        cmd.mul_sel = mm64_pkg::SEL_HFIN;
        cmd.mul_run = !st.mul_done;
        if (st.mul_done) cmd.wb = mm64_pkg::WB_HXS;
      end
      mm64_pkg::S_OUT: cmd.load_out = st.out_free;
      default: cmd.take = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/mm64_dp.sv
// ----------------------------------------------------------------------------
// mm64_dp
// Hash datapath: seed, running hash, word and length registers, the shared
// multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm64_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [63:0]    cfg_wdata,
  input  wire mm64_pkg::cmd_t cmd,
  output mm64_pkg::stat_t     st,
  mm64_in_if.sink             in_ch,
  mm64_out_if.source          out_ch
);

  mm64_pkg::word_t seed;
  mm64_pkg::word_t h;
  mm64_pkg::word_t k;
  mm64_pkg::len_t  len;
  mm64_pkg::len_t  len_eff;
  logic            at_start;
  logic            init;
  logic            last;
  logic            accept;
  logic            out_valid;
  mm64_pkg::word_t hash_value;
  mm64_pkg::word_t mul_a;
  mm64_pkg::word_t mul_p;
  logic            mul_done;

  assign accept  = cmd.take && in_ch.valid;
  assign len_eff = at_start ? in_ch.total_length : len;

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= mm64_pkg::SEED_RESET;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  // message framing
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
      init     <= 1'b0;
      last     <= 1'b0;
    end else if (accept) begin
      at_start <= in_ch.is_last;
      init     <= at_start;
      last     <= in_ch.is_last;
    end
  end

  // word and length capture, tail masked on the last beat
  always_ff @(posedge clk) begin
    if (accept) begin
      len <= len_eff;
      if (in_ch.is_last) begin
        k <= (len_eff[2:0] == 3'd0) ? in_ch.data_word
                                    : in_ch.data_word & mm64_pkg::tail_mask(len_eff[2:0]);
      end else begin
        k <= in_ch.data_word;
      end
    end else if (cmd.wb == mm64_pkg::WB_KXS) begin
      k <= mm64_pkg::xor_shift(mul_p);
    end else if (cmd.wb == mm64_pkg::WB_K) begin
      k <= mul_p;
    end
  end

  // running hash write-back
  always_ff @(posedge clk) begin
    unique case (cmd.wb)
      mm64_pkg::WB_SEED: h <= seed ^ mul_p;
      mm64_pkg::WB_H:    h <= mul_p;
      mm64_pkg::WB_HXS:  h <= mm64_pkg::xor_shift(mul_p);
      default:           h <= h;
    endcase
  end

  // multiplier operand
  always_comb begin
    unique case (cmd.mul_sel)
      mm64_pkg::SEL_LEN:  mul_a = {{(mm64_pkg::WORD_BITS - mm64_pkg::LENGTH_BITS){1'b0}}, len};
      mm64_pkg::SEL_K:    mul_a = k;
      mm64_pkg::SEL_HK:   mul_a = h ^ k;
      mm64_pkg::SEL_HFIN: mul_a = mm64_pkg::xor_shift(h);
      default:            mul_a = k;
    endcase
  end

  mm64_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .run  (cmd.mul_run),
    .a    (mul_a),
    .done (mul_done),
    .p    (mul_p)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hash_value <= h;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.hash_value = hash_value;
  // no beat is taken while reset is held
  assign in_ch.ready       = cmd.take && !rst;

  // status back to the controller
  always_comb begin
    st.in_valid  = in_ch.valid;
    st.init      = init;
    st.last      = last;
    st.tail_zero = (len[2:0] == 3'd0);
    st.len_zero  = (len == '0);
    st.mul_done  = mul_done;
    st.out_free  = !out_valid || out_ch.ready;
  end

  // checks
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> $past(cmd.mul_run))
    else $error("multiplier done without a run");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ch.ready))
    else $error("result register overwritten");

  a_no_take_while_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !cmd.mul_run)
    else $error("beat taken while multiplier busy");

  a_wb_with_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.wb != mm64_pkg::WB_NONE) |-> mul_done)
    else $error("write-back without a finished product");

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - streaming MurmurHash64A testbench
// Drives message words into the hash block and checks every finished hash
// against a cycle-free predictor. A table of directed beats covers the
// length corner cases, then seeded phases of random messages follow, with
// random gaps on both channels and one long hold-off on the hash output.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES    = 60;
  localparam int unsigned PHASE_WORDS     = 190;
  localparam int unsigned DIRECTED_ROWS   = 21;

  typedef enum logic {
    ROW_SEED,
    ROW_WORD
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    mm64_pkg::word_t value;
    mm64_pkg::len_t  len;
    logic            last;
    logic            typed;
    mm64_pkg::word_t typed_hash;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we;
  mm64_pkg::word_t cfg_wdata;

  mm64_in_if  in_ch ();
  mm64_out_if out_ch ();

  murmur64a_hash_stream DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  mm64_pkg::word_t hash_seed;
  mm64_pkg::word_t hash_state;
  mm64_pkg::len_t  message_len;
  logic            awaiting_first;

  mm64_pkg::word_t expected_hashes [$];
  stim_row_t       directed_rows [DIRECTED_ROWS];
  int unsigned     mismatches = 0;
  int unsigned     quiet_cycles = 0;
  logic            sender_steady = 1'b0;
  logic            hold_off_pending = 1'b0;
  mm64_pkg::word_t oldest_hash;

  always #1 clk = ~clk;

  // mix one full word into a key
  function automatic mm64_pkg::word_t scramble_key(input mm64_pkg::word_t k);
    mm64_pkg::word_t t;
    t = k * mm64_pkg::MUL_M;
    t = t ^ (t >> mm64_pkg::SHIFT_R);
    return t * mm64_pkg::MUL_M;
  endfunction

  // advance the hash by one beat, returns 1 when a hash is finished
  function automatic logic advance_hash(input mm64_pkg::word_t w, input mm64_pkg::len_t len,
                                        input logic last, output mm64_pkg::word_t finished);
    mm64_pkg::word_t h;
    int unsigned     tail;
    mm64_pkg::word_t keep;
    finished = '0;
    if (awaiting_first) begin
      message_len    = len;
      hash_state     = hash_seed ^ (mm64_pkg::word_t'(len) * mm64_pkg::MUL_M);
      awaiting_first = 1'b0;
    end
    h = hash_state;
    if (!last) begin
      hash_state = (h ^ scramble_key(w)) * mm64_pkg::MUL_M;
      return 1'b0;
    end
    tail = message_len % 8;
    if (tail != 0) begin
      keep = (mm64_pkg::word_t'(1) << (tail * 8)) - mm64_pkg::word_t'(1);
      h    = (h ^ (w & keep)) * mm64_pkg::MUL_M;
    end else if (message_len != 0) begin
      h = (h ^ scramble_key(w)) * mm64_pkg::MUL_M;
    end
    h = h ^ (h >> mm64_pkg::SHIFT_R);
    h = h * mm64_pkg::MUL_M;
    h = h ^ (h >> mm64_pkg::SHIFT_R);
    hash_state     = h;
    awaiting_first = 1'b1;
    finished       = h;
    return 1'b1;
  endfunction

  // gap length, mostly none, a few long
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one beat and wait for it to be taken
  task automatic feed_word(input mm64_pkg::word_t w, input mm64_pkg::len_t len,
                           input logic last, input logic typed,
                           input mm64_pkg::word_t typed_hash);
    mm64_pkg::word_t h;
    int unsigned     gap;
    in_ch.valid        <= 1'b1;
    in_ch.data_word    <= w;
    in_ch.total_length <= len;
    in_ch.is_last      <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (advance_hash(w, len, last, h)) begin
      expected_hashes.insert(expected_hashes.size(), typed ? typed_hash : h);
    end
    gap = sender_steady ? 0 : gap_cycles();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, let every hash arrive and the block go quiet
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(input mm64_pkg::word_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hash_seed = v;
  endtask

  // random messages under one seed, optional output hold-off once it starts
  task automatic run_random_phase(input mm64_pkg::word_t seed_value, input logic hold_off);
    int unsigned    fed;
    int unsigned    kind;
    int unsigned    len;
    int unsigned    n_words;
    mm64_pkg::len_t field;
    settle_block();
    load_seed(seed_value);
    if (hold_off) hold_off_pending = 1'b1;
    fed = 0;
    while (fed < PHASE_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // well-formed message, mostly short
        len     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 80);
        n_words = (len == 0) ? 1 : (len + 7) / 8;
      end else if (kind < 92) begin
        // any length, few words
        len     = $urandom_range(0, 65535);
        n_words = $urandom_range(1, 6);
      end else begin
        // word count off from the length
        len     = $urandom_range(0, 40);
        n_words = $urandom_range(1, 12);
      end
      sender_steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n_words; i++) begin
        field = (i == 0) ? mm64_pkg::len_t'(len) : mm64_pkg::len_t'($urandom_range(0, 65535));
        feed_word({$urandom, $urandom}, field, i == n_words - 1, 1'b0, '0);
      end
      fed += n_words;
    end
    sender_steady = 1'b0;
  endtask

  // stimulus
  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.data_word    <= '0;
    in_ch.total_length <= '0;
    in_ch.is_last      <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    hash_seed      = mm64_pkg::SEED_RESET;
    hash_state     = '0;
    message_len    = '0;
    awaiting_first = 1'b1;

    directed_rows = '{
      // default seed: empty message, data ignored
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0,      1'b1, 1'b0, 64'h0},
      // one full last word
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd8,      1'b1, 1'b0, 64'h0},
      // two words, length on second ignored
      '{ROW_WORD, 64'h0000_0000_0000_0000, 16'd16,     1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,   1'b1, 1'b0, 64'h0},
      // one-byte and seven-byte tails
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1,      1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0123_4567_89AB_CDEF, 16'd7,      1'b1, 1'b0, 64'h0},
      // max length, far too few words
      '{ROW_WORD, 64'h8000_0000_0000_0000, 16'hFFFF,   1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000,   1'b1, 1'b0, 64'h0},
      // tail word with junk in the high bytes
      '{ROW_WORD, 64'h5555_5555_5555_5555, 16'd9,      1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA,   1'b1, 1'b0, 64'h0},
      // zero seed: empty message hashes to zero
      '{ROW_SEED, 64'h0000_0000_0000_0000, 16'd0,      1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0,      1'b1, 1'b1, 64'h0},
      '{ROW_WORD, 64'h0000_0000_0000_0000, 16'd0,      1'b1, 1'b1, 64'h0},
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3,      1'b1, 1'b0, 64'h0},
      // multiple of eight on a single last word
      '{ROW_WORD, 64'hDEAD_BEEF_0BAD_F00D, 16'h8000,   1'b1, 1'b0, 64'h0},
      // all-ones seed
      '{ROW_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0,      1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0000_0000_0000_0000, 16'd0,      1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0000_0000_0000_0000, 16'd24,     1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd24,     1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0123_4567_89AB_CDEF, 16'd24,     1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FF8,   1'b1, 1'b0, 64'h0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_SEED) begin
        settle_block();
        load_seed(directed_rows[r].value);
      end else begin
        feed_word(directed_rows[r].value, directed_rows[r].len, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].typed_hash);
      end
    end

    // random phases, hold-off on the output early in the first
    run_random_phase({$urandom, $urandom}, 1'b1);
    run_random_phase(64'h0, 1'b0);
    run_random_phase(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    run_random_phase({$urandom, $urandom}, 1'b0);
    run_random_phase(mm64_pkg::SEED_RESET, 1'b0);

    settle_block();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hash receiver with random stalls
  initial begin
    int unsigned burst;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        // long hold-off so the block fills and stalls its input
        hold_off_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      burst = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
      stall = gap_cycles();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // compare each hash beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t: expected no hash, got %h", $time, out_ch.hash_value);
        mismatches++;
      end else begin
        oldest_hash = expected_hashes.pop_front();
        if (out_ch.hash_value !== oldest_hash) begin
          $display("%0t: hash expected %h, got %h", $time, oldest_hash, out_ch.hash_value);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat taken
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout after %0d idle cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### filelist.f
rtl/core/mm64_pkg.sv
rtl/core/mm64_ifs.sv
rtl/core/mm64_mul.sv
rtl/core/mm64_ctrl.sv
rtl/core/mm64_dp.sv
rtl/core/murmur64a_hash_stream.sv
test/tb.sv
